@@ hdl/rne_pkg.sv @@
// ----------------------------------------------------------------------------
// rne_pkg
// Shared types, codes and digit/letter tables of the roman numeral encoder.
// ----------------------------------------------------------------------------
package rne_pkg;

  localparam int unsigned ValueW  = 12;
  localparam int unsigned SymbolW = 8;
  localparam int unsigned DigitW  = 4;
  localparam int unsigned Places  = 4;

  localparam logic [SymbolW-1:0] CH_NONE = 8'h00;
  localparam logic [SymbolW-1:0] CH_I    = 8'h49;
  localparam logic [SymbolW-1:0] CH_V    = 8'h56;
  localparam logic [SymbolW-1:0] CH_X    = 8'h58;
  localparam logic [SymbolW-1:0] CH_L    = 8'h4C;
  localparam logic [SymbolW-1:0] CH_C    = 8'h43;
  localparam logic [SymbolW-1:0] CH_D    = 8'h44;
  localparam logic [SymbolW-1:0] CH_M    = 8'h4D;

  localparam logic [ValueW-1:0] VALUE_LIMIT = 12'd4000;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_ZERO  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    K_ONE  = 2'd0,
    K_FIVE = 2'd1,
    K_TEN  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    FE_IDLE  = 2'd0,
    FE_SPLIT = 2'd1,
    FE_PUSH  = 2'd2
  } fe_state_t;

  // one classified item: decimal digits, units first, and its status
  typedef struct packed {
    status_t                        status;
    logic [Places-1:0][DigitW-1:0]  digits;
  } desc_t;

  // d times the weight of a decimal place
  function automatic logic [13:0] place_multiple(input logic [1:0] place,
                                                 input logic [DigitW-1:0] d);
    logic [13:0] weight;
    unique case (place)
      2'd0: weight = 14'd1;
      2'd1: weight = 14'd10;
      2'd2: weight = 14'd100;
      2'd3: weight = 14'd1000;
      default: weight = 14'd0;
    endcase
    return 14'(14'(d) * weight);
  endfunction

  // digit of rem at a place, rem being below ten times its weight
  function automatic logic [DigitW-1:0] digit_of(input logic [ValueW-1:0] rem,
                                                 input logic [1:0] place);
    logic [DigitW-1:0] d;
    d = '0;
    for (int i = 1; i <= 9; i++) begin
      if ({2'b00, rem} >= place_multiple(place, DigitW'(i))) begin
        d = DigitW'(i);
      end
    end
    return d;
  endfunction

  function automatic logic [2:0] form_len(input logic [DigitW-1:0] d);
    logic [2:0] len;
    unique case (d)
      4'd1, 4'd5:         len = 3'd1;
      4'd2, 4'd4, 4'd6,
      4'd9:               len = 3'd2;
      4'd3, 4'd7:         len = 3'd3;
      4'd8:               len = 3'd4;
      default:            len = 3'd0;
    endcase
    return len;
  endfunction

  function automatic kind_t form_kind(input logic [DigitW-1:0] d,
                                      input logic [1:0] pos);
    kind_t k;
    unique case (d)
      4'd4:                     k = (pos == 2'd0) ? K_ONE : K_FIVE;
      4'd5, 4'd6, 4'd7, 4'd8:   k = (pos == 2'd0) ? K_FIVE : K_ONE;
      4'd9:                     k = (pos == 2'd0) ? K_ONE : K_TEN;
      default:                  k = K_ONE;
    endcase
    return k;
  endfunction

  function automatic logic [SymbolW-1:0] place_letter(input logic [1:0] place,
                                                      input kind_t k);
    logic [SymbolW-1:0] ch;
    unique case (place)
      2'd0: ch = (k == K_ONE) ? CH_I : ((k == K_FIVE) ? CH_V : CH_X);
      2'd1: ch = (k == K_ONE) ? CH_X : ((k == K_FIVE) ? CH_L : CH_C);
      2'd2: ch = (k == K_ONE) ? CH_C : ((k == K_FIVE) ? CH_D : CH_M);
      2'd3: ch = (k == K_ONE) ? CH_M : CH_NONE;
      default: ch = CH_NONE;
    endcase
    return ch;
  endfunction

endpackage

@@ hdl/rne_if.sv @@
// ----------------------------------------------------------------------------
// rne_in_if / rne_out_if
// Valid/ready channels of the roman numeral encoder.
// ----------------------------------------------------------------------------
interface rne_in_if;
  logic        valid;
  logic        ready;
  logic [11:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface rne_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol;
  logic       is_last;
  logic [1:0] status;

  modport source (output valid, output symbol, output is_last, output status,
                  input ready);
  modport sink   (input valid, input symbol, input is_last, input status,
                  output ready);
endinterface

@@ hdl/roman_numeral_encoder_core.sv @@
// ----------------------------------------------------------------------------
// roman_numeral_encoder_core
// Converts a 12-bit number into its roman numeral, one ASCII letter per item.
// ----------------------------------------------------------------------------
// in_ch carries one number per item. out_ch carries one letter per item with
// is_last on the final letter of a numeral and a status code: a zero input
// gives a single item with status zero, an input of 4000 or more a single
// item with status range, both with symbol 0.
// The front accepts a number, then splits it into decimal digits at one
// place per cycle (zero and out-of-range numbers skip the split), after
// which in_ch is ready again. A two-entry queue holds classified numbers
// for the back, which loads one when idle and then sends one letter per
// cycle while out_ch is not stalled; it takes the next number only after
// the last letter of the current one is registered.
// A stalled out_ch holds the current letter; the back and then the queue
// fill and the front waits, and in_ch drops ready. Synchronous reset empties
// the queue and the output register; no number is in flight afterwards.
// ----------------------------------------------------------------------------
module roman_numeral_encoder_core
  import rne_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  rne_in_if.sink     in_ch,
  rne_out_if.source  out_ch
);

  logic  push;
  logic  pop;
  logic  q_full;
  logic  q_empty;
  desc_t push_data;
  desc_t q_data;

  rne_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .push      (push),
    .push_data (push_data),
    .q_full    (q_full)
  );

  rne_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_data (push_data),
    .full    (q_full),
    .pop     (pop),
    .rd_data (q_data),
    .empty   (q_empty)
  );

  rne_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_data  (q_data),
    .q_empty (q_empty),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule

@@ hdl/rne_front.sv @@
// ----------------------------------------------------------------------------
// rne_front
// Accepts an item and classifies it; a valid one is split into decimal
// digits, one place per cycle. The result is then handed to the queue.
// ----------------------------------------------------------------------------
module rne_front
  import rne_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  rne_in_if.sink      in_ch,
  output logic        push,
  output desc_t       push_data,
  input  logic        q_full
);

  fe_state_t                     state_r, state_nxt;
  logic [ValueW-1:0]             rem_r, rem_nxt;
  logic [1:0]                    place_r, place_nxt;
  logic [Places-1:0][DigitW-1:0] digits_r, digits_nxt;
  status_t                       status_r, status_nxt;

  logic [DigitW-1:0] dig;
  logic [13:0]       dig_mult;

  assign dig      = digit_of(rem_r, place_r);
  assign dig_mult = place_multiple(place_r, dig);

  always_comb begin
    state_nxt   = state_r;
    rem_nxt     = rem_r;
    place_nxt   = place_r;
    digits_nxt  = digits_r;
    status_nxt  = status_r;
    in_ch.ready = 1'b0;
    push        = 1'b0;
    unique case (state_r)
      FE_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          rem_nxt    = in_ch.value;
          place_nxt  = 2'd3;
          digits_nxt = '0;
          if (in_ch.value == '0) begin
            status_nxt = ST_ZERO;
            state_nxt  = FE_PUSH;
          end else if (in_ch.value >= VALUE_LIMIT) begin
            status_nxt = ST_RANGE;
            state_nxt  = FE_PUSH;
          end else begin
            status_nxt = ST_OK;
            state_nxt  = FE_SPLIT;
          end
        end
      end
      FE_SPLIT: begin
        digits_nxt[place_r] = dig;
        rem_nxt             = rem_r - dig_mult[ValueW-1:0];
        if (place_r == 2'd0) begin
          state_nxt = FE_PUSH;
        end else begin
          place_nxt = place_r - 2'd1;
        end
      end
      FE_PUSH: begin
        if (!q_full) begin
          push      = 1'b1;
          state_nxt = FE_IDLE;
        end
      end
      default: state_nxt = FE_IDLE;
    endcase
  end

  assign push_data.status = status_r;
  assign push_data.digits = digits_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FE_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r    <= rem_nxt;
    place_r  <= place_nxt;
    digits_r <= digits_nxt;
    status_r <= status_nxt;
  end

endmodule

@@ hdl/rne_fifo.sv @@
// ----------------------------------------------------------------------------
// rne_fifo
// Two-entry queue of classified items between front and back.
// ----------------------------------------------------------------------------
module rne_fifo
  import rne_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  desc_t wr_data,
  output logic  full,
  input  logic  pop,
  output desc_t rd_data,
  output logic  empty
);

  desc_t      entry_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign full    = (count_r == 2'd2);
  assign empty   = (count_r == 2'd0);
  assign rd_data = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = ~wr_ptr_r;
    end
    if (pop) begin
      rd_ptr_nxt = ~rd_ptr_r;
    end
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

@@ hdl/rne_back.sv @@
// ----------------------------------------------------------------------------
// rne_back
// Takes classified items from the queue and emits one numeral letter per
// cycle, while out_ch is not stalled, through a registered output.
// ----------------------------------------------------------------------------
module rne_back
  import rne_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  desc_t  q_data,
  input  logic   q_empty,
  output logic   pop,
  rne_out_if.source out_ch
);

  desc_t             desc_r, desc_nxt;
  logic              active_r, active_nxt;
  logic [1:0]        place_r, place_nxt;
  logic [1:0]        pos_r, pos_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [SymbolW-1:0] symbol_r, symbol_nxt;
  logic              is_last_r, is_last_nxt;
  status_t           status_r, status_nxt;

  logic [DigitW-1:0]  cur_digit;
  logic [2:0]         cur_len;
  logic [SymbolW-1:0] cur_char;
  logic               pos_end;
  logic               below_found;
  logic [1:0]         below_place;
  logic [1:0]         start_place;
  logic               err;
  logic               last;
  logic               adv;

  // highest non-zero place below the current place, and highest non-zero place of the queue head
  always_comb begin
    below_found = 1'b0;
    below_place = 2'd0;
    start_place = 2'd0;
    for (int p = 0; p < Places; p++) begin
      if ((p < int'(place_r)) && (desc_r.digits[p] != '0)) begin
        below_found = 1'b1;
        below_place = 2'(p);
      end
      if (q_data.digits[p] != '0) begin
        start_place = 2'(p);
      end
    end
  end

  assign cur_digit = desc_r.digits[place_r];
  assign cur_len   = form_len(cur_digit);
  assign cur_char  = place_letter(place_r, form_kind(cur_digit, pos_r));
  assign pos_end   = ((3'(pos_r) + 3'd1) == cur_len);
  assign err       = (desc_r.status != ST_OK);
  assign last      = err || (pos_end && !below_found);
  assign adv       = !out_valid_r || out_ch.ready;
  assign pop       = !active_r && !q_empty;

  always_comb begin
    desc_nxt      = desc_r;
    active_nxt    = active_r;
    place_nxt     = place_r;
    pos_nxt       = pos_r;
    out_valid_nxt = out_valid_r;
    symbol_nxt    = symbol_r;
    is_last_nxt   = is_last_r;
    status_nxt    = status_r;
    if (pop) begin
      desc_nxt   = q_data;
      active_nxt = 1'b1;
      place_nxt  = start_place;
      pos_nxt    = 2'd0;
    end
    if (adv) begin
      out_valid_nxt = 1'b0;
      if (active_r) begin
        out_valid_nxt = 1'b1;
        symbol_nxt    = err ? CH_NONE : cur_char;
        is_last_nxt   = last;
        status_nxt    = desc_r.status;
        if (last) begin
          active_nxt = 1'b0;
        end else if (pos_end) begin
          place_nxt = below_place;
          pos_nxt   = 2'd0;
        end else begin
          pos_nxt = pos_r + 2'd1;
        end
      end
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.symbol  = symbol_r;
  assign out_ch.is_last = is_last_r;
  assign out_ch.status  = status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    desc_r    <= desc_nxt;
    place_r   <= place_nxt;
    pos_r     <= pos_nxt;
    symbol_r  <= symbol_nxt;
    is_last_r <= is_last_nxt;
    status_r  <= status_nxt;
  end

endmodule

@@ dv/roman_numeral_encoder_core_tb.sv @@
// ----------------------------------------------------------------------------
// roman_numeral_encoder_core_tb
// Self-checking bench for the roman numeral encoder core.
// ----------------------------------------------------------------------------
// A short directed table comes first: zero, both ends of the out-of-range
// band, digits 4 and 9 at each of the lower three places, the longest numeral
// and the largest valid number. Random numbers follow, mostly valid and
// weighted towards long numerals. Each letter leaving the core is checked
// against a local encoder or its typed row. Both channels pause at random,
// with one full-rate stretch; the sender twice waits for the core to drain.
// ----------------------------------------------------------------------------
module roman_numeral_encoder_core_tb;
  import rne_pkg::*;

  localparam int unsigned RandomItems   = 206;
  localparam int unsigned DirectedItems = 24;
  localparam int unsigned TailCycles    = 40;
  localparam int unsigned IdleLimit     = 3000;

  localparam logic [SymbolW-1:0] ONE_LETTER  [Places] = '{CH_I, CH_X, CH_C, CH_M};
  localparam logic [SymbolW-1:0] FIVE_LETTER [Places] = '{CH_V, CH_L, CH_D, CH_NONE};
  localparam logic [SymbolW-1:0] TEN_LETTER  [Places] = '{CH_X, CH_C, CH_M, CH_NONE};

  typedef struct {
    logic [SymbolW-1:0] symbol;
    logic               is_last;
    status_t            status;
  } letter_t;

  typedef struct {
    logic [ValueW-1:0]  value;
    bit                 typed;
    logic [SymbolW-1:0] symbol;
    status_t            status;
  } number_row_t;

  // typed rows give a single letter, so is_last is always set
  number_row_t number_table [DirectedItems] = '{
    '{12'd0,    1'b1, CH_NONE, ST_ZERO},
    '{12'd1,    1'b1, CH_I,    ST_OK},
    '{12'd5,    1'b1, CH_V,    ST_OK},
    '{12'd10,   1'b1, CH_X,    ST_OK},
    '{12'd1000, 1'b1, CH_M,    ST_OK},
    '{12'd4000, 1'b1, CH_NONE, ST_RANGE},
    '{12'd4095, 1'b1, CH_NONE, ST_RANGE},
    '{12'd4,    1'b0, CH_NONE, ST_OK},
    '{12'd9,    1'b0, CH_NONE, ST_OK},
    '{12'd40,   1'b0, CH_NONE, ST_OK},
    '{12'd49,   1'b0, CH_NONE, ST_OK},
    '{12'd90,   1'b0, CH_NONE, ST_OK},
    '{12'd99,   1'b0, CH_NONE, ST_OK},
    '{12'd400,  1'b0, CH_NONE, ST_OK},
    '{12'd444,  1'b0, CH_NONE, ST_OK},
    '{12'd900,  1'b0, CH_NONE, ST_OK},
    '{12'd999,  1'b0, CH_NONE, ST_OK},
    '{12'd1994, 1'b0, CH_NONE, ST_OK},
    '{12'd2421, 1'b0, CH_NONE, ST_OK},
    '{12'd3888, 1'b0, CH_NONE, ST_OK},
    '{12'd3999, 1'b0, CH_NONE, ST_OK},
    '{12'd2048, 1'b0, CH_NONE, ST_OK},
    '{12'd1365, 1'b0, CH_NONE, ST_OK},
    '{12'd2730, 1'b0, CH_NONE, ST_OK}
  };

  logic clk = 1'b0;
  logic rst_n;

  rne_in_if  in_ch ();
  rne_out_if out_ch ();

  roman_numeral_encoder_core uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  letter_t     expected_letters[$];
  int unsigned mismatch_count  = 0;
  int unsigned letters_checked = 0;
  int unsigned numbers_sent    = 0;
  int unsigned zero_count      = 0;
  int unsigned range_count     = 0;
  int unsigned idle_cycles     = 0;
  int unsigned stall_left      = 0;
  bit          steady          = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // mostly short pauses, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    else if (r < 85) return $urandom_range(1, 3);
    else if (r < 97) return $urandom_range(4, 10);
    else return $urandom_range(20, 60);
  endfunction

  function automatic logic [ValueW-1:0] random_number();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 6) return '0;
    else if (r < 16) return ValueW'($urandom_range(4000, 4095));
    else if (r < 26) return ValueW'($urandom_range(1, 3) * 1000 + $urandom_range(7, 8) * 100 +
                                    $urandom_range(7, 8) * 10 + $urandom_range(7, 8));
    else return ValueW'($urandom_range(1, 3999));
  endfunction

  function automatic void encode_numeral(input logic [ValueW-1:0] num);
    logic [SymbolW-1:0] run[$];
    letter_t            letter;
    int unsigned        rest;
    int unsigned        weight;
    int unsigned        d;
    rest   = num;
    weight = 1000;
    if (num == '0) begin
      letter = '{CH_NONE, 1'b1, ST_ZERO};
      expected_letters.push_back(letter);
    end else if (num >= VALUE_LIMIT) begin
      letter = '{CH_NONE, 1'b1, ST_RANGE};
      expected_letters.push_back(letter);
    end else begin
      for (int p = Places - 1; p >= 0; p--) begin
        d      = rest / weight;
        rest   = rest % weight;
        weight = weight / 10;
        case (d)
          1, 2, 3: repeat (d) run.push_back(ONE_LETTER[p]);
          4: begin
            run.push_back(ONE_LETTER[p]);
            run.push_back(FIVE_LETTER[p]);
          end
          5, 6, 7, 8: begin
            run.push_back(FIVE_LETTER[p]);
            repeat (d - 5) run.push_back(ONE_LETTER[p]);
          end
          9: begin
            run.push_back(ONE_LETTER[p]);
            run.push_back(TEN_LETTER[p]);
          end
          default: ;
        endcase
      end
      foreach (run[k]) begin
        letter = '{run[k], (k == run.size() - 1), ST_OK};
        expected_letters.push_back(letter);
      end
    end
  endfunction

  task automatic send_number(input logic [ValueW-1:0] num, input bit typed,
                             input letter_t typed_letter);
    int unsigned gap;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      in_ch.value <= ValueW'($urandom);
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.value <= num;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (typed) expected_letters.push_back(typed_letter);
    else encode_numeral(num);
    numbers_sent++;
    if (num == '0) zero_count++;
    else if (num >= VALUE_LIMIT) range_count++;
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (expected_letters.size() != 0);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if (!steady && $urandom_range(0, 99) < 25) begin
      out_ch.ready <= 1'b0;
      stall_left   <= pick_gap();
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_letters
    letter_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_letters.size() == 0) begin
        $display("%0t: unexpected item symbol=%h is_last=%0d status=%0d", $time,
                 out_ch.symbol, out_ch.is_last, out_ch.status);
        mismatch_count++;
      end else begin
        want = expected_letters.pop_front();
        letters_checked++;
        if (out_ch.symbol !== want.symbol) begin
          $display("%0t: symbol expected %h actual %h", $time, want.symbol, out_ch.symbol);
          mismatch_count++;
        end
        if (out_ch.is_last !== want.is_last) begin
          $display("%0t: is_last expected %0d actual %0d", $time, want.is_last,
                   out_ch.is_last);
          mismatch_count++;
        end
        if (out_ch.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status,
                   out_ch.status);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
        $display("%0t: no item accepted for %0d cycles", $time, idle_cycles);
        $display("Verification failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    letter_t typed_letter;
    in_ch.valid  = 1'b0;
    in_ch.value  = '0;
    rst_n        = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (number_table[i]) begin
      typed_letter = '{number_table[i].symbol, 1'b1, number_table[i].status};
      send_number(number_table[i].value, number_table[i].typed, typed_letter);
    end
    wait_drained();

    typed_letter = '{CH_NONE, 1'b0, ST_OK};
    for (int unsigned n = 0; n < RandomItems; n++) begin
      if (n == 80) steady = 1'b1;
      if (n == 120) steady = 1'b0;
      if (n == 160) wait_drained();
      send_number(random_number(), 1'b0, typed_letter);
    end
    in_ch.valid <= 1'b0;

    do @(posedge clk); while (expected_letters.size() != 0);
    repeat (TailCycles) @(posedge clk);

    $display("%0d numbers encoded (%0d zero, %0d out of range), %0d letters checked",
             numbers_sent, zero_count, range_count, letters_checked);
    $display("random pauses on both channels, one full-rate stretch, two full drains");
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ roman_numeral_encoder_core.f @@
hdl/rne_pkg.sv
hdl/rne_if.sv
hdl/rne_front.sv
hdl/rne_fifo.sv
hdl/rne_back.sv
hdl/roman_numeral_encoder_core.sv
dv/roman_numeral_encoder_core_tb.sv
